// ----- sv/pid_step_clamped_defines.svh -----
// ----------------------------------------------------------------------------
// pid_step_clamped_defines.svh
// Assertion macros used by the checker file pidsc_chk.
// ----------------------------------------------------------------------------
`ifndef PID_STEP_CLAMPED_DEFINES_SVH
`define PID_STEP_CLAMPED_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PIDSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pidsc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PIDSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidsc assertion failed");

`endif

// ----- sv/pidsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pidsc_pkg
// Widths, register indexes and saturation helpers for the PID step block.
// ----------------------------------------------------------------------------
package pidsc_pkg;

  localparam int DataW  = 32;
  localparam int OpW    = 33;           // multiplier operand, holds unsigned 31-bit period
  localparam int ProdW  = 2 * OpW;
  localparam int QShift = 16;
  localparam int IdxW   = 4;

  localparam logic [IdxW-1:0] REG_GAIN_P        = 4'd0;
  localparam logic [IdxW-1:0] REG_GAIN_I        = 4'd1;
  localparam logic [IdxW-1:0] REG_GAIN_D        = 4'd2;
  localparam logic [IdxW-1:0] REG_SAMPLE_PERIOD = 4'd3;
  localparam logic [IdxW-1:0] REG_INTEGRAL_MIN  = 4'd4;
  localparam logic [IdxW-1:0] REG_INTEGRAL_MAX  = 4'd5;
  localparam logic [IdxW-1:0] REG_OUTPUT_MIN    = 4'd6;
  localparam logic [IdxW-1:0] REG_OUTPUT_MAX    = 4'd7;

  localparam logic signed [DataW-1:0] SMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] SMin = 32'sh8000_0000;

  // Saturate a 33-bit signed difference to 32 bits.
  function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] x);
    logic signed [DataW-1:0] r;
    if (x > 33'sh0_7FFF_FFFF) begin
      r = SMax;
    end else if (x < -33'sh0_8000_0000) begin
      r = SMin;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // Clamp a 34-bit signed sum to [lo, hi]; when inverted, x below lo gives lo, else hi.
  function automatic logic signed [DataW-1:0] clamp34(input logic signed [DataW+1:0] x,
                                                      input logic signed [DataW-1:0] lo,
                                                      input logic signed [DataW-1:0] hi);
    logic signed [DataW-1:0] r;
    if (x < $signed({{2{lo[DataW-1]}}, lo})) begin
      r = lo;
    end else if (x > $signed({{2{hi[DataW-1]}}, hi})) begin
      r = hi;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/pidsc_mul.sv -----
// ----------------------------------------------------------------------------
// pidsc_mul
// Shared Q16.16 multiplier: registered 33x33 product, floor shift, saturate.
// ----------------------------------------------------------------------------
module pidsc_mul (
  input  logic                                clk,
  input  logic signed [pidsc_pkg::OpW-1:0]    a,
  input  logic signed [pidsc_pkg::OpW-1:0]    b,
  output logic signed [pidsc_pkg::DataW-1:0]  res
);
  import pidsc_pkg::*;

  logic signed [ProdW-1:0]        prod;
  logic signed [ProdW-QShift-1:0] shifted;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // arithmetic shift of two's complement is a floor
  assign shifted = prod[ProdW-1:QShift];

  always_comb begin
    if (shifted > $signed({{(ProdW-QShift-DataW){1'b0}}, SMax})) begin
      res = SMax;
    end else if (shifted < $signed({{(ProdW-QShift-DataW){1'b1}}, SMin})) begin
      res = SMin;
    end else begin
      res = shifted[DataW-1:0];
    end
  end

endmodule

// ----- sv/pid_step_clamped.sv -----
// ----------------------------------------------------------------------------
// pid_step_clamped
// Discrete PID step with integral clamp and output clamp, signed Q16.16.
// ----------------------------------------------------------------------------
// Each accepted (measured, target) pair yields one drive value. The error is
// target - measured, saturated. P = err*gain_p, the integral grows by
// (err*sample_period)*gain_i and is clamped to [integral_min, integral_max],
// D = (prev_err - err)*gain_d, and drive = P+I+D clamped to
// [output_min, output_max]. Every product is exact, floored by 16 bits and
// saturated to 32 bits. The next item is taken only once the sequencer is
// back in idle: the four products go one after another through a single
// registered multiplier, under an eight-state sequencer. The result
// sits in an output register, so a new item is taken while the last result
// still waits downstream. Integral and last error clear at reset. Config
// writes are always taken (cfg_ready high); indexes past 7 are dropped.
// Write config only while the block is idle.
// ----------------------------------------------------------------------------
module pid_step_clamped (
  input  logic                                 clk,
  input  logic                                 rst,
  // input item
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pidsc_pkg::DataW-1:0]   measured,
  input  logic signed [pidsc_pkg::DataW-1:0]   target,
  // result item
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidsc_pkg::DataW-1:0]   drive,
  // config writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [pidsc_pkg::IdxW-1:0]    cfg_index,
  input  logic        [pidsc_pkg::DataW-1:0]   cfg_data
);
  import pidsc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,  // wait for input
    ST_P    = 8'b0000_0010,  // issue err*gain_p, form derivative diff
    ST_T    = 8'b0000_0100,  // take P, issue err*period
    ST_D    = 8'b0000_1000,  // take err*period, issue diff*gain_d
    ST_I    = 8'b0001_0000,  // take D, issue increment product
    ST_A    = 8'b0010_0000,  // take increment, clamp and store integral
    ST_S    = 8'b0100_0000,  // final sum and output clamp
    ST_W    = 8'b1000_0000   // hand result to output register
  } state_t;

  state_t state, state_next;

  // config registers
  logic signed [DataW-1:0] gain_p, gain_i, gain_d;
  logic        [DataW-2:0] sample_period;
  logic signed [DataW-1:0] integral_min, integral_max, output_min, output_max;

  // controller state
  logic signed [DataW-1:0] integral_acc, prev_error;
  logic                    primed;

  // per-item working registers
  logic signed [DataW-1:0] err, diff, p_term, t_term, d_term, sum_q;

  logic signed [OpW-1:0]   mul_a, mul_b;
  logic signed [DataW-1:0] mul_res;
  logic                    in_xfer, out_xfer;
  logic signed [DataW-1:0] acc_eff, last_eff, i_clamped;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign acc_eff  = primed ? integral_acc : '0;
  assign last_eff = primed ? prev_error   : '0;

  assign i_clamped = clamp34({{2{acc_eff[DataW-1]}}, acc_eff}
                             + {{2{mul_res[DataW-1]}}, mul_res},
                             integral_min, integral_max);

  pidsc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = {err[DataW-1], err};
    mul_b = {gain_p[DataW-1], gain_p};
    case (state)
      ST_T: mul_b = {2'b00, sample_period};
      ST_D: begin
        mul_a = {diff[DataW-1], diff};
        mul_b = {gain_d[DataW-1], gain_d};
      end
      ST_I: begin
        mul_a = {t_term[DataW-1], t_term};
        mul_b = {gain_i[DataW-1], gain_i};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_P;
      ST_P:    state_next = ST_T;
      ST_T:    state_next = ST_D;
      ST_D:    state_next = ST_I;
      ST_I:    state_next = ST_A;
      ST_A:    state_next = ST_S;
      ST_S:    state_next = ST_W;
      ST_W:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      sample_period <= 31'd65536;
      integral_min  <= SMin;
      integral_max  <= SMax;
      output_min    <= SMin;
      output_max    <= SMax;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:        gain_p        <= cfg_data;
        REG_GAIN_I:        gain_i        <= cfg_data;
        REG_GAIN_D:        gain_d        <= cfg_data;
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[DataW-2:0];
        REG_INTEGRAL_MIN:  integral_min  <= cfg_data;
        REG_INTEGRAL_MAX:  integral_max  <= cfg_data;
        REG_OUTPUT_MIN:    output_min    <= cfg_data;
        REG_OUTPUT_MAX:    output_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_xfer) err <= sat33({target[DataW-1], target}
                                         - {measured[DataW-1], measured});
      ST_P:    diff   <= sat33({last_eff[DataW-1], last_eff} - {err[DataW-1], err});
      ST_T:    p_term <= mul_res;
      ST_D:    t_term <= mul_res;
      ST_I:    d_term <= mul_res;
      ST_S:    sum_q  <= clamp34({{2{p_term[DataW-1]}}, p_term}
                                 + {{2{integral_acc[DataW-1]}}, integral_acc}
                                 + {{2{d_term[DataW-1]}}, d_term},
                                 output_min, output_max);
      default: ;
    endcase
  end

  // controller state: integral and last error commit once the increment lands
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      prev_error   <= '0;
      primed       <= 1'b0;
    end else if (state == ST_A) begin
      integral_acc <= i_clamped;
      prev_error   <= err;
      primed       <= 1'b1;
    end
  end

  // output register: loads from ST_W when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_W && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_W && (!out_valid || !out_stall)) begin
      drive <= sum_q;
    end
  end

endmodule

// ----- sv/pidsc_chk.sv -----
// ----------------------------------------------------------------------------
// pidsc_chk
// Port-level checks for pid_step_clamped, bound to the top level.
// ----------------------------------------------------------------------------
`include "pid_step_clamped_defines.svh"

module pidsc_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [pidsc_pkg::DataW-1:0]  drive
);
  import pidsc_pkg::*;

  // held result stays put
  `PIDSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive))
  // after a transfer in the sequencer is busy
  `PIDSC_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
  // a new result only appears at the end of a busy stretch
  `PIDSC_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind pid_step_clamped pidsc_chk u_pidsc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive)
);
